// File: design/trds_pkg.sv
`timescale 1ns / 1ps
package trds_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int NUM_W = 15;   // |origin - pos| fits in 15 bits
  localparam int DIV_W = 10;   // (64 - speed) * accel <= 64 * 15
  localparam int QCNT_W = 4;

  localparam logic [2:0] CFG_TRACKPAD = 3'd0;
  localparam logic [2:0] CFG_SCROLL   = 3'd1;
  localparam logic [2:0] CFG_ACCEL    = 3'd2;
  localparam logic [2:0] CFG_SPEED    = 3'd3;
  localparam logic [2:0] CFG_RAW      = 3'd4;
  localparam logic [2:0] CFG_WINDOW   = 3'd5;
  localparam logic [2:0] CFG_ACCDEF   = 3'd6;

  localparam logic [3:0] ST_NONE  = 4'h0;
  localparam logic [3:0] ST_START = 4'h3;
  localparam logic [3:0] ST_DRAG  = 4'h4;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [DIV_W-1:0] den;
  } trds_div_req_t;

  typedef struct packed {
    logic done;
    logic [NUM_W-1:0] quo;
  } trds_div_rsp_t;
endpackage

// File: design/trds_divider.sv
`timescale 1ns / 1ps
module trds_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  trds_pkg::trds_div_req_t req,
  output trds_pkg::trds_div_rsp_t rsp
);
  import trds_pkg::*;

  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]  den_r, den_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W+1:0]  shifted;

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[NUM_W-1]};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = QCNT_W'(NUM_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {2'b00, den_r}) begin
        rem_nxt = (DIV_W+1)'(shifted - {2'b00, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
endmodule

// File: design/touch_record_decode_scroll.sv
`timescale 1ns / 1ps
// A record passes through S_DEC and S_FIN to S_OUT; a drag with scroll on
// also runs two divisions (S_DIVX, S_DIVY) on one shared restoring divider, one
// per axis; the block accepts no new record until the result is taken.
// Reset (rst_n, synchronous, active low) restores register defaults and
// clears all per-slot tables and the down count; acceleration resets to 7.
module touch_record_decode_scroll (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_raw_slot,
  input  logic [31:0] in_now_ticks,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic [7:0]  in_byte_4,
  input  logic [7:0]  in_byte_5,
  input  logic [7:0]  in_byte_6,
  input  logic [7:0]  in_byte_7,
  input  logic [7:0]  in_byte_8,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_slot,
  output logic        out_down,
  output logic [9:0]  out_major_axis,
  output logic [9:0]  out_minor_axis,
  output logic signed [6:0]  out_orient,
  output logic signed [12:0] out_pos_x,
  output logic signed [13:0] out_pos_y,
  output logic signed [14:0] out_hwheel_step,
  output logic signed [14:0] out_wheel_step,
  output logic [7:0]  out_raw_state_byte,
  output logic        out_raw_valid,
  output logic [7:0]  out_active_count
);
  import trds_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_DIVX = 3'd2;
  localparam logic [2:0] S_DIVY = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic        trackpad_r, scroll_on_r, accel_on_r, raw_on_r;
  logic [5:0]  speed_r;
  logic [15:0] window_r;
  logic [3:0]  accdef_r;

  logic [SLOT_W-1:0] slot_of_raw_r [SLOTS];
  logic [12:0] touch_x_r [SLOTS];
  logic [12:0] touch_y_r [SLOTS];
  logic [5:0]  touch_size_r [SLOTS];
  logic signed [13:0] org_x_r [SLOTS];
  logic signed [13:0] org_y_r [SLOTS];
  logic [3:0]  accel_r;
  logic [31:0] last_time_r;
  logic [7:0]  down_cnt_r;

  // Captured request.
  logic [3:0]  raw_r;
  logic [31:0] now_r;
  logic [7:0]  b_r [9];

  // Decoded fields.
  logic [3:0]  id_r;
  logic signed [13:0] x_r, y_r;
  logic [5:0]  size_r;
  logic [7:0]  ob_r, maj_r, min_r, sbyte_r;
  logic [DIV_W-1:0] den_r;
  logic        negx_r, negy_r;
  logic signed [14:0] hstep_r, vstep_r;

  trds_div_req_t dreq;
  trds_div_rsp_t drsp;

  trds_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);

  // Decode of the captured bytes.
  logic [3:0]  d_id;
  logic signed [13:0] d_x, d_y;
  logic [5:0]  d_size;
  logic [7:0]  d_ob, d_maj, d_min, d_sb;
  logic [12:0] ux, uy;
  always_comb begin
    if (!trackpad_r) begin
      d_id   = {b_r[6][1:0], b_r[5][7:6]};
      ux     = {{1{b_r[1][3]}}, b_r[1][3:0], b_r[0]};
      uy     = {{1{b_r[2][7]}}, b_r[2], b_r[1][7:4]};
      d_size = b_r[5][5:0];
      d_ob   = b_r[6];
      d_maj  = b_r[3];
      d_min  = b_r[4];
      d_sb   = b_r[7];
    end else begin
      d_id   = {b_r[7][1:0], b_r[6][7:6]};
      ux     = {b_r[1][4:0], b_r[0]};
      uy     = {b_r[3][1:0], b_r[2], b_r[1][7:5]};
      d_size = b_r[6][5:0];
      d_ob   = b_r[7];
      d_maj  = b_r[4];
      d_min  = b_r[5];
      d_sb   = b_r[8];
    end
    d_x = {ux[12], ux};
    d_y = 14'sd0 - {uy[12], uy};
  end

  logic [3:0] code;
  logic       down;
  assign code = sbyte_r[7:4];
  assign down = (code != ST_NONE);

  logic signed [14:0] diff_x, diff_y;
  assign diff_x = 15'(org_x_r[id_r]) - 15'(x_r);
  assign diff_y = 15'(org_y_r[id_r]) - 15'(y_r);

  logic [31:0] limit, tdelta;
  assign limit  = last_time_r + 32'(window_r);
  assign tdelta = now_r - limit;

  // The quotient is valid on the divider output in the cycle that done is high.
  logic [NUM_W+DIV_W-1:0] qprod;
  assign qprod = drsp.quo * den_r;

  always_comb begin
    state_nxt = state_r;
    dreq.start = 1'b0;
    dreq.num = '0;
    dreq.den = den_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_FIN;
      S_FIN: begin
        if (scroll_on_r && code == ST_DRAG) begin
          dreq.start = 1'b1;
          dreq.num = diff_x[14] ? NUM_W'(-diff_x) : NUM_W'(diff_x);
          state_nxt = S_DIVX;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVX: if (drsp.done) begin
        dreq.start = 1'b1;
        dreq.num = diff_y[14] ? NUM_W'(-diff_y) : NUM_W'(diff_y);
        state_nxt = S_DIVY;
      end
      S_DIVY: if (drsp.done) state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trackpad_r  <= 1'b0;
      scroll_on_r <= 1'b1;
      accel_on_r  <= 1'b1;
      speed_r     <= 6'd32;
      raw_on_r    <= 1'b0;
      window_r    <= 16'd125;
      accdef_r    <= 4'd7;
      accel_r     <= 4'd7;
      last_time_r <= '0;
      down_cnt_r  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_of_raw_r[i] <= '0;
        touch_x_r[i] <= '0;
        touch_y_r[i] <= '0;
        touch_size_r[i] <= '0;
        org_x_r[i] <= '0;
        org_y_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TRACKPAD: trackpad_r  <= cfg_data[0];
          CFG_SCROLL:   scroll_on_r <= cfg_data[0];
          CFG_ACCEL:    accel_on_r  <= cfg_data[0];
          CFG_SPEED:    speed_r     <= cfg_data[5:0];
          CFG_RAW:      raw_on_r    <= cfg_data[0];
          CFG_WINDOW:   window_r    <= cfg_data;
          CFG_ACCDEF:   accdef_r    <= cfg_data[3:0];
          default: ;
        endcase
      end
      case (state_r)
        S_FIN: begin
          slot_of_raw_r[raw_r] <= id_r;
          touch_x_r[id_r] <= x_r[12:0];
          touch_y_r[id_r] <= y_r[12:0];
          touch_size_r[id_r] <= size_r;
          if (down) down_cnt_r <= down_cnt_r + 8'd1;
          if (scroll_on_r && code == ST_START) begin
            org_x_r[id_r] <= x_r;
            org_y_r[id_r] <= y_r;
            if (accel_on_r && tdelta[31])
              accel_r <= (accel_r > 4'd1) ? accel_r - 4'd1 : 4'd1;
            else
              accel_r <= (accdef_r == 4'd0) ? 4'd1 : accdef_r;
          end
        end
        S_DIVX: if (drsp.done && drsp.quo != '0) begin
          org_x_r[id_r] <= negx_r ? 14'(org_x_r[id_r] + 14'(qprod))
                                  : 14'(org_x_r[id_r] - 14'(qprod));
          last_time_r <= now_r;
        end
        S_DIVY: if (drsp.done && drsp.quo != '0) begin
          org_y_r[id_r] <= negy_r ? 14'(org_y_r[id_r] + 14'(qprod))
                                  : 14'(org_y_r[id_r] - 14'(qprod));
          last_time_r <= now_r;
        end
        default: ;
      endcase
    end
    // Datapath registers.
    case (state_r)
      S_IDLE: begin
        raw_r <= in_raw_slot;
        now_r <= in_now_ticks;
        b_r[0] <= in_byte_0; b_r[1] <= in_byte_1; b_r[2] <= in_byte_2;
        b_r[3] <= in_byte_3; b_r[4] <= in_byte_4; b_r[5] <= in_byte_5;
        b_r[6] <= in_byte_6; b_r[7] <= in_byte_7; b_r[8] <= in_byte_8;
        hstep_r <= '0;
        vstep_r <= '0;
      end
      S_DEC: begin
        id_r <= d_id; x_r <= d_x; y_r <= d_y; size_r <= d_size;
        ob_r <= d_ob; maj_r <= d_maj; min_r <= d_min; sbyte_r <= d_sb;
        den_r <= DIV_W'((7'd64 - {1'b0, speed_r}) * accel_r);
      end
      S_FIN: begin
        negx_r <= diff_x[14];
        negy_r <= diff_y[14];
      end
      S_DIVX: if (drsp.done) begin
        // Step is -qx; qx carries the sign of diff_x.
        hstep_r <= negx_r ? $signed(15'(drsp.quo)) : -$signed(15'(drsp.quo));
      end
      S_DIVY: if (drsp.done) begin
        vstep_r <= negy_r ? -$signed(15'(drsp.quo)) : $signed(15'(drsp.quo));
      end
      default: ;
    endcase
  end

  logic raw_rep;
  assign raw_rep = down && raw_on_r;

  assign out_slot           = id_r;
  assign out_down           = down;
  assign out_major_axis     = down ? {maj_r, 2'b00} : '0;
  assign out_minor_axis     = down ? {min_r, 2'b00} : '0;
  assign out_orient         = down ? (7'sd32 - $signed({1'b0, ob_r[7:2]})) : '0;
  assign out_pos_x          = down ? x_r[12:0] : '0;
  assign out_pos_y          = down ? y_r : '0;
  assign out_hwheel_step    = hstep_r;
  assign out_wheel_step     = vstep_r;
  assign out_raw_state_byte = raw_rep ? sbyte_r : '0;
  assign out_raw_valid      = raw_rep;
  assign out_active_count   = down_cnt_r;
endmodule

// File: verif/touch_record_decode_scroll_test.sv
`timescale 1ns / 1ps
module touch_record_decode_scroll_test;
  import trds_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [3:0]  raw;
    logic [31:0] now;
    logic [7:0]  b [9];
  } touch_rec_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        down;
    logic [9:0]  major_axis;
    logic [9:0]  minor_axis;
    logic [6:0]  orient;
    logic [12:0] pos_x;
    logic [13:0] pos_y;
    logic [14:0] hwheel_step;
    logic [14:0] wheel_step;
    logic [7:0]  raw_state_byte;
    logic        raw_valid;
    logic [7:0]  active_count;
  } touch_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_raw_slot;
  logic [31:0] in_now_ticks;
  logic [7:0]  in_byte_0, in_byte_1, in_byte_2, in_byte_3, in_byte_4;
  logic [7:0]  in_byte_5, in_byte_6, in_byte_7, in_byte_8;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_slot;
  logic        out_down;
  logic [9:0]  out_major_axis;
  logic [9:0]  out_minor_axis;
  logic signed [6:0]  out_orient;
  logic signed [12:0] out_pos_x;
  logic signed [13:0] out_pos_y;
  logic signed [14:0] out_hwheel_step;
  logic signed [14:0] out_wheel_step;
  logic [7:0]  out_raw_state_byte;
  logic        out_raw_valid;
  logic [7:0]  out_active_count;

  touch_record_decode_scroll uut (.*);

  // Shadow registers and per-slot state of the decoder.
  logic        sh_trackpad, sh_scroll_on, sh_accel_on, sh_raw;
  logic [5:0]  sh_speed;
  logic [15:0] sh_window;
  logic [3:0]  sh_accel_def;
  int          org_x [SLOTS];
  int          org_y [SLOTS];
  int          accel_factor;
  logic [31:0] last_scroll;
  logic [7:0]  down_total;

  touch_event_t expected_events [$];
  int  mismatches;
  bit  failed;
  bit  idling_on;
  int  hold_cycles;
  int  hold_req;
  int  hold_ack;
  int  quiet_cycles;
  logic [31:0] tick;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int sext(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return int'(v ^ m) - int'(m);
  endfunction

  function automatic touch_event_t decode_touch(touch_rec_t r);
    touch_event_t e;
    logic [3:0] id;
    logic [7:0] ob, maj, mnr, sb;
    logic [3:0] code;
    int x, y, dvs, qx, qy, hs, vs;
    logic [31:0] lim, diff;
    hs = 0;
    vs = 0;
    if (!sh_trackpad) begin
      id = {r.b[6][1:0], r.b[5][7:6]};
      x = sext({r.b[1][3:0], r.b[0]}, 12);
      y = -sext({r.b[2], r.b[1][7:4]}, 12);
      ob = r.b[6]; maj = r.b[3]; mnr = r.b[4]; sb = r.b[7];
    end else begin
      id = {r.b[7][1:0], r.b[6][7:6]};
      x = sext({r.b[1][4:0], r.b[0]}, 13);
      y = -sext({r.b[3][1:0], r.b[2], r.b[1][7:5]}, 13);
      ob = r.b[7]; maj = r.b[4]; mnr = r.b[5]; sb = r.b[8];
    end
    code = sb[7:4];
    if (sh_scroll_on) begin
      if (code == ST_START) begin
        org_x[id] = x;
        org_y[id] = y;
        lim = last_scroll + 32'(sh_window);
        diff = r.now - lim;
        if (sh_accel_on && diff[31])
          accel_factor = (accel_factor > 1) ? accel_factor - 1 : 1;
        else
          accel_factor = (sh_accel_def == 0) ? 1 : int'(sh_accel_def);
      end else if (code == ST_DRAG) begin
        dvs = (64 - int'(sh_speed)) * accel_factor;
        qx = (org_x[id] - x) / dvs;
        qy = (org_y[id] - y) / dvs;
        if (qx != 0) begin
          org_x[id] -= qx * dvs;
          last_scroll = r.now;
          hs = -qx;
        end
        if (qy != 0) begin
          org_y[id] -= qy * dvs;
          last_scroll = r.now;
          vs = qy;
        end
      end
    end
    e = '0;
    e.down = (code != ST_NONE);
    if (e.down) begin
      down_total++;
      e.major_axis = {maj, 2'b00};
      e.minor_axis = {mnr, 2'b00};
      e.orient = 7'(32 - int'(ob >> 2));
      e.pos_x = 13'(x);
      e.pos_y = 14'(y);
      e.raw_state_byte = sh_raw ? sb : 8'd0;
      e.raw_valid = sh_raw;
    end
    e.slot = id;
    e.hwheel_step = 15'(hs);
    e.wheel_step = 15'(vs);
    e.active_count = down_total;
    return e;
  endfunction

  // Scoreboard: configuration and records are folded into the shadow state
  // in acceptance order; results are checked against the oldest event.
  always @(posedge clk) begin
    touch_rec_t r;
    touch_event_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready || out_valid && out_ready || cfg_valid && cfg_ready)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TRACKPAD: sh_trackpad = cfg_data[0];
          CFG_SCROLL:   sh_scroll_on = cfg_data[0];
          CFG_ACCEL:    sh_accel_on = cfg_data[0];
          CFG_SPEED:    sh_speed = cfg_data[5:0];
          CFG_RAW:      sh_raw = cfg_data[0];
          CFG_WINDOW:   sh_window = cfg_data;
          CFG_ACCDEF:   sh_accel_def = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_slot, out_down, out_major_axis, out_minor_axis, out_orient,
                out_pos_x, out_pos_y, out_hwheel_step, out_wheel_step,
                out_raw_state_byte, out_raw_valid, out_active_count};
        if (expected_events.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected touch event at %0t", $realtime);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        r.raw = in_raw_slot;
        r.now = in_now_ticks;
        r.b = '{in_byte_0, in_byte_1, in_byte_2, in_byte_3, in_byte_4,
                in_byte_5, in_byte_6, in_byte_7, in_byte_8};
        expected_events.push_back(decode_touch(r));
      end
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stall bursts plus one long hold-off on request.
  always @(posedge clk) begin
    int burst;
    burst = 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cycles <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      burst = $urandom_range(1, 5);
      hold_cycles <= burst - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_record(touch_rec_t r);
    in_raw_slot <= r.raw;
    in_now_ticks <= r.now;
    in_byte_0 <= r.b[0]; in_byte_1 <= r.b[1]; in_byte_2 <= r.b[2];
    in_byte_3 <= r.b[3]; in_byte_4 <= r.b[4]; in_byte_5 <= r.b[5];
    in_byte_6 <= r.b[6]; in_byte_7 <= r.b[7]; in_byte_8 <= r.b[8];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(bit tp, bit scr, bit acc, int spd, bit rawr, int win, int adef);
    wait_drained();
    write_reg(CFG_TRACKPAD, 16'(tp));
    write_reg(CFG_SCROLL, 16'(scr));
    write_reg(CFG_ACCEL, 16'(acc));
    write_reg(CFG_SPEED, 16'(spd));
    write_reg(CFG_RAW, 16'(rawr));
    write_reg(CFG_WINDOW, 16'(win));
    write_reg(CFG_ACCDEF, 16'(adef));
  endtask

  // Builds a record for the current layout; bytes not carrying a field stay random.
  function automatic touch_rec_t make_rec(logic [3:0] raw, logic [3:0] id, int x, int y,
                                          logic [7:0] sb);
    touch_rec_t r;
    logic [12:0] xr, yr;
    r.raw = raw;
    r.now = tick;
    foreach (r.b[i]) r.b[i] = 8'($urandom);
    xr = 13'(x);
    yr = 13'(-y);
    r.b[0] = xr[7:0];
    if (!sh_trackpad) begin
      r.b[1] = {yr[3:0], xr[11:8]};
      r.b[2] = yr[11:4];
      r.b[5][7:6] = id[1:0];
      r.b[6][1:0] = id[3:2];
      r.b[7] = sb;
    end else begin
      r.b[1] = {yr[2:0], xr[12:8]};
      r.b[2] = yr[10:3];
      r.b[3][1:0] = yr[12:11];
      r.b[6][7:6] = id[1:0];
      r.b[7][1:0] = id[3:2];
      r.b[8] = sb;
    end
    return r;
  endfunction

  function automatic logic [7:0] state_byte(logic [3:0] code);
    return {code, 4'($urandom)};
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic test_field_extremes();
    touch_rec_t r;
    set_mode(0, 1, 1, 32, 1, 125, 7);
    send_record(make_rec(4'd0, 4'd0, -2048, 2048, state_byte(ST_START)));
    send_record(make_rec(4'd15, 4'd15, 2047, -2047, state_byte(ST_START)));
    r = make_rec(4'd5, 4'd9, 0, 0, 8'hff);
    r.b[3] = 8'hff; r.b[4] = 8'hff; r.b[6] = 8'hfe;
    send_record(r);
    r = make_rec(4'd6, 4'd3, 0, 0, 8'h0f);
    send_record(r);
    foreach (r.b[i]) r.b[i] = 8'hff;
    send_record(r);
    foreach (r.b[i]) r.b[i] = 8'h00;
    send_record(r);
    set_mode(1, 1, 1, 32, 1, 125, 7);
    send_record(make_rec(4'd1, 4'd2, -4096, 4096, state_byte(ST_START)));
    send_record(make_rec(4'd1, 4'd2, 4095, -4095, state_byte(ST_DRAG)));
    send_record(make_rec(4'd2, 4'd4, 4095, -4095, state_byte(ST_START)));
    send_record(make_rec(4'd2, 4'd4, -4096, 4096, state_byte(ST_DRAG)));
  endtask

  task automatic test_each_state();
    set_mode(0, 1, 1, 63, 0, 125, 15);
    send_record(make_rec(4'd3, 4'd7, 100, 100, state_byte(ST_START)));
    send_record(make_rec(4'd3, 4'd7, 40, 170, state_byte(ST_DRAG)));
    send_record(make_rec(4'd3, 4'd7, 40, 170, state_byte(ST_NONE)));
    send_record(make_rec(4'd3, 4'd7, -500, 900, state_byte(4'h7)));
    send_record(make_rec(4'd3, 4'd7, 500, -900, state_byte(ST_DRAG)));
  endtask

  task automatic test_accel_window();
    // Zero default loads a factor of one; quick restarts then stay at one.
    set_mode(0, 1, 1, 0, 0, 1, 0);
    tick = 32'hffff_fff0;
    send_record(make_rec(4'd4, 4'd1, 0, 0, state_byte(ST_START)));
    send_record(make_rec(4'd4, 4'd1, 1000, -1000, state_byte(ST_DRAG)));
    send_record(make_rec(4'd4, 4'd1, 0, 0, state_byte(ST_START)));
    tick = tick + 32;
    send_record(make_rec(4'd4, 4'd1, 0, 0, state_byte(ST_START)));
    set_mode(0, 1, 1, 0, 0, 65535, 15);
    send_record(make_rec(4'd4, 4'd1, 0, 0, state_byte(ST_START)));
    send_record(make_rec(4'd4, 4'd1, 0, 0, state_byte(ST_START)));
  endtask

  // Mostly touch gestures (a start then drags) with random content, some noise.
  task automatic test_random_gestures(int n);
    int sent, cnt, x, y, lim, step;
    logic [3:0] id, raw;
    touch_rec_t r;
    sent = 0;
    lim = sh_trackpad ? 4095 : 2047;
    while (sent < n) begin
      tick = ($urandom_range(0, 15) == 0) ? $urandom : tick + $urandom_range(0, 250);
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < 9; i++) r.b[i] = 8'($urandom);
        r.raw = 4'($urandom);
        r.now = tick;
        send_record(r);
        sent++;
      end else begin
        id = 4'($urandom);
        raw = 4'($urandom);
        x = $urandom_range(0, 2 * lim) - lim;
        y = $urandom_range(0, 2 * lim) - lim + 1;
        send_record(make_rec(raw, id, x, y, state_byte(ST_START)));
        sent++;
        cnt = $urandom_range(2, 10);
        step = ($urandom_range(0, 3) == 0) ? 3000 : 300;
        for (int k = 0; k < cnt; k++) begin
          tick = tick + $urandom_range(0, 100);
          x = clamp(x + $urandom_range(0, 2 * step) - step, -lim - 1, lim);
          y = clamp(y + $urandom_range(0, 2 * step) - step, -lim + 1, lim + 1);
          send_record(make_rec(raw, id, x, y,
                               state_byte(($urandom_range(0, 9) == 0) ? ST_NONE : ST_DRAG)));
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_mode(1, 1, 1, 40, 1, 300, 5);
    @(posedge clk);
    hold_req = hold_req + 1;
    test_random_gestures(30);
    // Sender stops until every event has been delivered.
    wait_drained();
    test_random_gestures(20);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TRACKPAD;
    cfg_data = '0;
    in_raw_slot = '0;
    in_now_ticks = '0;
    {in_byte_0, in_byte_1, in_byte_2, in_byte_3, in_byte_4} = '0;
    {in_byte_5, in_byte_6, in_byte_7, in_byte_8} = '0;
    sh_trackpad = 0; sh_scroll_on = 1; sh_accel_on = 1; sh_speed = 32;
    sh_raw = 0; sh_window = 125; sh_accel_def = 7;
    foreach (org_x[i]) begin
      org_x[i] = 0;
      org_y[i] = 0;
    end
    accel_factor = 7;
    last_scroll = '0;
    down_total = '0;
    mismatches = 0;
    failed = 1'b0;
    hold_cycles = 0;
    hold_req = 0;
    hold_ack = 0;
    quiet_cycles = 0;
    tick = '0;
    idling_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults first, before any register write.
    test_random_gestures(150);
    test_field_extremes();
    test_each_state();
    test_accel_window();
    test_backpressure();
    set_mode(0, 1, 1, 63, 1, 1, 15);
    test_random_gestures(250);
    set_mode(1, 1, 1, 0, 0, 65535, 1);
    test_random_gestures(250);
    set_mode(0, 0, 1, 20, 1, 500, 3);
    test_random_gestures(150);
    set_mode(1, 1, 0, 50, 0, 125, 9);
    test_random_gestures(250);
    set_mode(0, 1, 1, 60, 0, 2000, 2);
    test_random_gestures(250);
    set_mode(1, 1, 1, 56, 1, 400, 15);
    idling_on = 1'b0;
    test_random_gestures(440);
    wait_drained();

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
